// File: design/psbaq_pkg.sv
// ----------------------------------------------------------------------------
// PCM segment byte accounting queue package
// Operation and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package psbaq_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTES_W  = 24;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned BPF_W    = 6;
  localparam int unsigned REM_W    = BPF_W + 1;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [OP_W-1:0] OP_PCM_WRITTEN = 3'd0;
  localparam logic [OP_W-1:0] OP_QUEUE_CHG   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_META   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_PCM    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOSE       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END_OF_STRM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP_CLOSED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROP_FULL    = 3'd4;

  localparam logic [BPF_W-1:0] BPF_RESET = 6'd4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

endpackage

// File: design/pcm_segment_byte_accounting_queue.sv
// ----------------------------------------------------------------------------
// PCM segment byte accounting queue
// Counts audio bytes against a ring queue of pending segment changes.
// ----------------------------------------------------------------------------
// An item is accepted on a rising edge with start high and busy low; its
// fields are op, byte_count, command_tag and metadata_tag. Every item gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. The block is busy until that result appears.
// Most items go from accept to result in order: a fetch of the queue entry
// from the change memory, an update of the state and a registered result.
// A PCM read that is not at end of stream also rounds the grant down to
// whole frames in a remainder unit that handles one bit of the 24-bit
// grant per cycle, before its result is shown.
// A new item can be accepted in the same cycle as the previous result.
// The frame size register sits at byte address 0 of the APB-style port and
// should be written only while the block is idle; pready is always high.
// Reset empties the queue, clears the byte count and the closed flag and
// sets the frame size to 4. The change memory needs no clearing pass.
// ----------------------------------------------------------------------------
module pcm_segment_byte_accounting_queue
  import psbaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [BYTES_W-1:0]    in_byte_count,
  input  logic [TAG_W-1:0]      in_command_tag,
  input  logic [TAG_W-1:0]      in_metadata_tag,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [BYTES_W-1:0]    out_granted_bytes,
  output logic [TAG_W-1:0]      out_ack_command_tag,
  output logic [TAG_W-1:0]      out_metadata_tag,
  output logic                  out_metadata_valid,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  localparam int unsigned QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned MAXW = (COUNT_BITS > BYTES_W) ? COUNT_BITS : BYTES_W;
  localparam int unsigned SUMW = MAXW + 1;

  state_t state_r, state_nxt;

  logic [QW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic                  closed_r, closed_nxt;
  logic [BPF_W-1:0]      bpf_r;

  logic [OP_W-1:0]       op_r;
  logic [BYTES_W-1:0]    count_r;
  logic [TAG_W-1:0]      ctag_r, mtag_r;

  logic [TAG_W-1:0]      cmd_mem  [QUEUE_DEPTH];
  logic [TAG_W-1:0]      meta_mem [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem  [QUEUE_DEPTH];
  logic [TAG_W-1:0]      rd_cmd_r, rd_meta_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic [QW-1:0]         rd_addr, wr_addr;
  logic                  tag_we, cnt_we;
  logic [COUNT_BITS-1:0] wr_cnt;

  logic [BYTES_W-1:0]    g_r, g_nxt, div_r, div_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [BYTES_W-1:0]    grant_r, grant_nxt;
  logic [TAG_W-1:0]      ack_r, ack_nxt, meta_r, meta_nxt;
  logic                  mvalid_r, mvalid_nxt;

  logic                  empty, full, accept, cfg_we;
  logic [QW-1:0]         head_inc, tail_inc, head_dec;
  logic [COUNT_BITS-1:0] sat_a, sat_sum;
  logic [SUMW-1:0]       sum_raw;
  logic [MAXW-1:0]       left_ext, req_ext;
  logic [BYTES_W-1:0]    g_min, g_rnd;
  logic [REM_W-1:0]      bpf_eff, trial;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cfg_we   = psel && penable && pwrite && !paddr[2];
  assign pready   = 1'b1;
  assign prdata   = APB_W'(bpf_r);

  assign empty    = (head_r == tail_r);
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_dec = (head_r == '0) ? QW'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign full     = (head_inc == tail_r);
  assign rd_addr  = (op_r == OP_READ_META) ? tail_r : head_dec;

  assign sat_a    = empty ? left_r : rd_cnt_r;
  assign sum_raw  = SUMW'(sat_a) + SUMW'(count_r);
  assign sat_sum  = (sum_raw > SUMW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                          : COUNT_BITS'(sum_raw);

  assign left_ext = MAXW'(left_r);
  assign req_ext  = MAXW'(count_r);
  assign g_min    = (left_ext < req_ext) ? BYTES_W'(left_ext) : count_r;
  assign g_rnd    = g_r - BYTES_W'(rem_r);

  assign bpf_eff  = (bpf_r == '0) ? REM_W'(1) : REM_W'(bpf_r);
  assign trial    = {rem_r[REM_W-2:0], div_r[BYTES_W-1]};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    left_nxt      = left_r;
    closed_nxt    = closed_r;
    g_nxt         = g_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    grant_nxt     = grant_r;
    ack_nxt       = ack_r;
    meta_nxt      = meta_r;
    mvalid_nxt    = mvalid_r;
    tag_we        = 1'b0;
    cnt_we        = 1'b0;
    wr_addr       = head_r;
    wr_cnt        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_DONE;
        grant_nxt     = '0;
        ack_nxt       = '0;
        meta_nxt      = '0;
        mvalid_nxt    = 1'b0;
        unique case (op_r)
          OP_PCM_WRITTEN: begin
            if (closed_r) begin
              status_nxt = ST_DROP_CLOSED;
            end else if (count_r != '0) begin
              if (!empty) begin
                cnt_we  = 1'b1;
                wr_addr = head_dec;
                wr_cnt  = sat_sum;
              end else begin
                left_nxt = sat_sum;
              end
            end
          end
          OP_QUEUE_CHG: begin
            if (closed_r) begin
              status_nxt = ST_DROP_CLOSED;
            end else if (full) begin
              status_nxt = ST_DROP_FULL;
            end else begin
              tag_we   = 1'b1;
              cnt_we   = 1'b1;
              head_nxt = head_inc;
            end
          end
          OP_READ_META: begin
            if (empty || left_r != '0) begin
              status_nxt = ST_NOT_READY;
            end else begin
              left_nxt   = rd_cnt_r;
              ack_nxt    = rd_cmd_r;
              meta_nxt   = rd_meta_r;
              mvalid_nxt = 1'b1;
              tail_nxt   = tail_inc;
            end
          end
          OP_READ_PCM: begin
            if (left_r == '0 && empty && closed_r) begin
              status_nxt = ST_END_OF_STRM;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_DIV;
              g_nxt         = g_min;
              div_nxt       = g_min;
              rem_nxt       = '0;
              step_nxt      = '0;
            end
          end
          OP_CLOSE: begin
            closed_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        rem_nxt  = (trial >= bpf_eff) ? trial - bpf_eff : trial;
        div_nxt  = {div_r[BYTES_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(BYTES_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (g_rnd == '0) begin
          status_nxt = ST_NOT_READY;
          grant_nxt  = '0;
        end else begin
          status_nxt = ST_DONE;
          grant_nxt  = g_rnd;
          left_nxt   = COUNT_BITS'(left_ext - MAXW'(g_rnd));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      left_r      <= '0;
      closed_r    <= 1'b0;
      bpf_r       <= BPF_RESET;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      left_r      <= left_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      if (cfg_we) begin
        bpf_r <= pwdata[BPF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      count_r <= in_byte_count;
      ctag_r  <= in_command_tag;
      mtag_r  <= in_metadata_tag;
    end
    g_r      <= g_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    ack_r    <= ack_nxt;
    meta_r   <= meta_nxt;
    mvalid_r <= mvalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      cmd_mem[wr_addr]  <= ctag_r;
      meta_mem[wr_addr] <= mtag_r;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (state_r == S_FETCH) begin
      rd_cmd_r  <= cmd_mem[rd_addr];
      rd_meta_r <= meta_mem[rd_addr];
      rd_cnt_r  <= cnt_mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_granted_bytes   = grant_r;
  assign out_ack_command_tag = ack_r;
  assign out_metadata_tag    = meta_r;
  assign out_metadata_valid  = mvalid_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EXEC || $past(state_r) == S_FIN))
    else $error("result strobe without a finishing step");

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_FETCH)
    else $error("accepted item did not start a fetch");

  a_grant_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_granted_bytes != '0 |->
      out_status == ST_DONE && !out_metadata_valid)
    else $error("grant with a bad status");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_metadata_valid |->
      out_status == ST_DONE && $past(tail_r) != tail_r)
    else $error("segment change popped without a tail step");

endmodule
